// ===== rtl/tqlru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqlru_pkg
// Shared types and constants for the tenant quota LRU replacement unit.
// ----------------------------------------------------------------------------
package tqlru_pkg;

    // default sizes
    localparam int SLOTS_DEF     = 16;
    localparam int TENANTS_DEF   = 4;
    localparam int PAGE_BITS_DEF = 16;

    // fixed field widths
    localparam int TID_W    = 2;
    localparam int TID_N    = 1 << TID_W;
    localparam int PRIO_W   = 7;
    localparam int QUOTA_W  = 5;
    localparam int SLOT_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    // widest slot index and age rank over the supported slot range
    localparam int IDX_W = 6;
    localparam int AGE_W = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PRIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAXQ = 2'd2;

    localparam logic [27:0] PRIO_RESET = 28'd0;
    localparam logic [19:0] MINQ_RESET = 20'd0;
    localparam logic [19:0] MAXQ_RESET = 20'd541200;

    // record handed from cell to cell during the scan
    typedef struct packed {
        logic             hit_f;
        logic [IDX_W-1:0] hit_s;
        logic [AGE_W-1:0] hit_a;
        logic             own_f;
        logic [IDX_W-1:0] own_s;
        logic [AGE_W-1:0] own_a;
        logic             vic_f;
        logic [IDX_W-1:0] vic_s;
        logic [AGE_W-1:0] vic_a;
        logic [PRIO_W-1:0] vic_p;
        logic [TID_W-1:0] vic_o;
    } scan_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_RECENT,
        UPD_FILL
    } upd_op_t;

    // update command broadcast to every cell
    typedef struct packed {
        upd_op_t          op;
        logic [IDX_W-1:0] slot;
        logic [AGE_W-1:0] ref_age;
        logic             wr_page;
        logic             wr_owner;
    } upd_t;

endpackage

// ===== rtl/tqlru_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqlru_if
// Valid/ready channels: page request, lookup response, register write.
// ----------------------------------------------------------------------------
interface tqlru_req_if #(parameter int PAGE_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [1:0]           tenant_id;
    logic [PAGE_BITS-1:0] page_number;
    modport source (output valid, tenant_id, page_number, input ready);
    modport sink   (input valid, tenant_id, page_number, output ready);
endinterface

interface tqlru_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] slot_index;
    logic       was_hit;
    logic       status;
    modport source (output valid, slot_index, was_hit, status, input ready);
    modport sink   (input valid, slot_index, was_hit, status, output ready);
endinterface

interface tqlru_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [27:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/tqlru_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqlru_cell
// One buffer slot: holds valid, owner, page and age rank, folds itself into
// the scan record from its left neighbor and applies broadcast updates.
// ----------------------------------------------------------------------------
module tqlru_cell #(
    parameter int IDX       = 0,
    parameter int SLOTS     = tqlru_pkg::SLOTS_DEF,
    parameter int PAGE_BITS = tqlru_pkg::PAGE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tqlru_pkg::scan_t              scan_in,
    output tqlru_pkg::scan_t              scan_out,
    input  logic [tqlru_pkg::TID_W-1:0]   req_tenant,
    input  logic [PAGE_BITS-1:0]          req_page,
    input  logic [tqlru_pkg::TID_N-1:0]   elig,
    input  logic [tqlru_pkg::PRIO_W-1:0]  prio [tqlru_pkg::TID_N],
    input  tqlru_pkg::upd_t               upd
);
    import tqlru_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                 valid_reg;
    logic [AW-1:0]        age_reg;
    logic [TID_W-1:0]     owner_reg;
    logic [PAGE_BITS-1:0] page_reg;
    scan_t                scan_reg;
    scan_t                scan_next;
    logic                 mine;
    logic [AGE_W-1:0]     age_x;
    logic [PRIO_W-1:0]    my_prio;

    assign age_x   = AGE_W'(age_reg);
    assign mine    = valid_reg && (owner_reg == req_tenant);
    assign my_prio = prio[owner_reg];

    // fold this slot into the passing record
    always_comb
    begin
        scan_next = scan_in;
        if (mine && (page_reg == req_page) && !scan_in.hit_f)
        begin
            scan_next.hit_f = 1'b1;
            scan_next.hit_s = MY_IDX;
            scan_next.hit_a = age_x;
        end
        if (mine && (!scan_in.own_f || age_x > scan_in.own_a))
        begin
            scan_next.own_f = 1'b1;
            scan_next.own_s = MY_IDX;
            scan_next.own_a = age_x;
        end
        if (valid_reg && elig[owner_reg] &&
            (!scan_in.vic_f || my_prio < scan_in.vic_p ||
             (my_prio == scan_in.vic_p && age_x > scan_in.vic_a)))
        begin
            scan_next.vic_f = 1'b1;
            scan_next.vic_s = MY_IDX;
            scan_next.vic_a = age_x;
            scan_next.vic_p = my_prio;
            scan_next.vic_o = owner_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    assign scan_out = scan_reg;

    // slot control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
        end
        else
        begin
            case (upd.op)
                UPD_FILL:
                begin
                    if (upd.slot == MY_IDX)
                    begin
                        valid_reg <= 1'b1;
                        age_reg   <= '0;
                    end
                    else if (valid_reg)
                    begin
                        age_reg <= age_reg + AW'(1);
                    end
                end
                UPD_RECENT:
                begin
                    if (upd.slot == MY_IDX)
                    begin
                        age_reg <= '0;
                    end
                    else if (valid_reg && age_x < upd.ref_age)
                    begin
                        age_reg <= age_reg + AW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        if (upd.slot == MY_IDX)
        begin
            if (upd.op == UPD_FILL || (upd.op == UPD_RECENT && upd.wr_owner))
            begin
                owner_reg <= req_tenant;
            end
            if (upd.op == UPD_FILL || (upd.op == UPD_RECENT && upd.wr_page))
            begin
                page_reg <= req_page;
            end
        end
    end

endmodule

// ===== rtl/tenant_quota_lru_replacement_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tenant_quota_lru_replacement_unit
// Quota partitioned LRU page buffer shared by several tenants.
// ----------------------------------------------------------------------------
// sequence: accept the request into registers, walk the scan record along the
//   slot cell chain one cell per cycle, then decide and register the response
//   word once the output register is free; one request is in flight at a time
// the next request is taken while a response waits in the output register
// reset: all slots empty, counts zero, registers at their reset values
// ----------------------------------------------------------------------------
module tenant_quota_lru_replacement_unit #(
    parameter int SLOTS     = tqlru_pkg::SLOTS_DEF,
    parameter int TENANTS   = tqlru_pkg::TENANTS_DEF,
    parameter int PAGE_BITS = tqlru_pkg::PAGE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tqlru_req_if.sink   req,
    tqlru_rsp_if.source rsp,
    tqlru_cfg_if.sink   cfg
);
    import tqlru_pkg::*;

    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t               state_reg;
    logic [SW-1:0]        scan_cnt_reg;
    logic [TID_W-1:0]     tenant_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [27:0]          prio_tab_reg;
    logic [19:0]          minq_tab_reg;
    logic [19:0]          maxq_tab_reg;
    logic [CW-1:0]        count_reg [TID_N];
    logic [CW-1:0]        count_next [TID_N];
    logic [CW-1:0]        filled_reg;
    logic                 out_valid_reg;
    logic [SLOT_W-1:0]    out_slot_reg;
    logic                 out_hit_reg;
    logic                 out_status_reg;

    scan_t                chain [SLOTS+1];
    logic [TID_N-1:0]     elig;
    logic [PRIO_W-1:0]    prio [TID_N];
    upd_t                 upd_d;
    upd_t                 upd_go;
    scan_t                fin;
    logic                 go;
    logic                 d_refuse;
    logic                 d_hit;
    logic [IDX_W-1:0]     d_slot;
    logic                 d_inc;
    logic                 d_dec;
    logic                 d_fill;
    logic [QUOTA_W-1:0]   maxq;

    assign req.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.slot_index = out_slot_reg;
    assign rsp.was_hit    = out_hit_reg;
    assign rsp.status     = out_status_reg;

    // per tenant eligibility and priority
    always_comb
    begin
        for (int t = 0; t < TID_N; t++)
        begin
            logic [QUOTA_W-1:0] mn;
            mn      = minq_tab_reg[t*QUOTA_W +: QUOTA_W];
            prio[t] = prio_tab_reg[t*PRIO_W +: PRIO_W];
            elig[t] = (t < TENANTS) &&
                      ((32'(count_reg[t]) > 32'(mn)) ||
                       (TID_W'(t) == tenant_reg && 32'(count_reg[t]) >= 32'(mn)));
        end
    end

    // slot cell chain
    assign chain[0] = '0;
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        tqlru_cell #(
            .IDX       (i),
            .SLOTS     (SLOTS),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .scan_in    (chain[i]),
            .scan_out   (chain[i+1]),
            .req_tenant (tenant_reg),
            .req_page   (page_reg),
            .elig       (elig),
            .prio       (prio),
            .upd        (upd_go)
        );
    end
    assign fin = chain[SLOTS];

    assign maxq = maxq_tab_reg[tenant_reg*QUOTA_W +: QUOTA_W];
    assign go   = (state_reg == ST_DECIDE) && (!out_valid_reg || rsp.ready);

    // decision on the finished scan record
    always_comb
    begin
        d_refuse = 1'b1;
        d_hit    = 1'b0;
        d_slot   = '0;
        d_inc    = 1'b0;
        d_dec    = 1'b0;
        d_fill   = 1'b0;
        upd_d    = '{op: UPD_NONE, slot: '0, ref_age: '0, wr_page: 1'b0, wr_owner: 1'b0};
        if (32'(tenant_reg) < TENANTS)
        begin
            if (fin.hit_f)
            begin
                d_refuse      = 1'b0;
                d_hit         = 1'b1;
                d_slot        = fin.hit_s;
                upd_d.op      = UPD_RECENT;
                upd_d.slot    = fin.hit_s;
                upd_d.ref_age = fin.hit_a;
            end
            else if (32'(count_reg[tenant_reg]) == 32'(maxq))
            begin
                if (fin.own_f)
                begin
                    d_refuse      = 1'b0;
                    d_slot        = fin.own_s;
                    upd_d.op      = UPD_RECENT;
                    upd_d.slot    = fin.own_s;
                    upd_d.ref_age = fin.own_a;
                    upd_d.wr_page = 1'b1;
                end
            end
            else if (32'(filled_reg) < SLOTS)
            begin
                d_refuse   = 1'b0;
                d_slot     = IDX_W'(filled_reg);
                d_inc      = 1'b1;
                d_fill     = 1'b1;
                upd_d.op   = UPD_FILL;
                upd_d.slot = IDX_W'(filled_reg);
            end
            else if (fin.vic_f)
            begin
                d_refuse       = 1'b0;
                d_slot         = fin.vic_s;
                d_inc          = 1'b1;
                d_dec          = 1'b1;
                upd_d.op       = UPD_RECENT;
                upd_d.slot     = fin.vic_s;
                upd_d.ref_age  = fin.vic_a;
                upd_d.wr_page  = 1'b1;
                upd_d.wr_owner = 1'b1;
            end
        end
        upd_go = upd_d;
        if (!go)
        begin
            upd_go.op = UPD_NONE;
        end
    end

    // tenant slot counts after this request
    always_comb
    begin
        for (int t = 0; t < TID_N; t++)
        begin
            count_next[t] = count_reg[t];
            if (d_inc && TID_W'(t) == tenant_reg)
            begin
                count_next[t] = count_next[t] + CW'(1);
            end
            if (d_dec && TID_W'(t) == fin.vic_o)
            begin
                count_next[t] = count_next[t] - CW'(1);
            end
        end
    end

    // sequencer, counts, registers and response word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            scan_cnt_reg   <= '0;
            prio_tab_reg   <= PRIO_RESET;
            minq_tab_reg   <= MINQ_RESET;
            maxq_tab_reg   <= MAXQ_RESET;
            filled_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_slot_reg   <= '0;
            out_hit_reg    <= 1'b0;
            out_status_reg <= 1'b0;
            tenant_reg     <= '0;
            page_reg       <= '0;
            for (int t = 0; t < TID_N; t++)
            begin
                count_reg[t] <= '0;
            end
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_PRIO: prio_tab_reg <= cfg.data;
                    REG_MINQ: minq_tab_reg <= cfg.data[19:0];
                    REG_MAXQ: maxq_tab_reg <= cfg.data[19:0];
                    default:
                    begin
                    end
                endcase
            end
            if (rsp.ready && !go)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        tenant_reg   <= req.tenant_id;
                        page_reg     <= req.page_number;
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_cnt_reg == SW'(SLOTS - 1))
                    begin
                        state_reg <= ST_DECIDE;
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + SW'(1);
                    end
                end
                ST_DECIDE:
                begin
                    if (go)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_slot_reg   <= d_refuse ? '0 : SLOT_W'(d_slot);
                        out_hit_reg    <= d_hit;
                        out_status_reg <= d_refuse;
                        if (d_fill)
                        begin
                            filled_reg <= filled_reg + CW'(1);
                        end
                        for (int t = 0; t < TID_N; t++)
                        begin
                            count_reg[t] <= count_next[t];
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/tqlru_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqlru_chk
// Port level checks for the tenant quota LRU replacement unit.
// ----------------------------------------------------------------------------
module tqlru_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [3:0] rsp_slot_index,
    input logic       rsp_was_hit,
    input logic       rsp_status
);

    // a waiting response word stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // a refused request reports slot zero and no hit
    a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |-> !rsp_was_hit && rsp_slot_index == 4'd0)
        else $error("refusal word not clean");

    // one request at a time: busy right after an accept
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // no response word appears right after an accept
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && !rsp_valid |=> !rsp_valid)
        else $error("response too early");

endmodule

bind tenant_quota_lru_replacement_unit tqlru_chk u_tqlru_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_slot_index (rsp.slot_index),
    .rsp_was_hit    (rsp.was_hit),
    .rsp_status     (rsp.status)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the tenant quota LRU replacement unit against a cycle-free model of
// the shared page buffer: slot lookup, quota reuse, in-order fill and
// priority/age victim choice, under several register settings and with
// random idling on the request and response channels.
// ----------------------------------------------------------------------------
module testbench;
    import tqlru_pkg::*;

    localparam int NSLOT   = SLOTS_DEF;
    localparam int NTEN    = TENANTS_DEF;
    localparam int SETTLE  = NSLOT + 8;
    localparam int STALL_LIMIT = 4000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [TID_W-1:0]         tenant;
        logic [PAGE_BITS_DEF-1:0] page;
    } page_req_t;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              hit;
        logic              status;
    } slot_grant_t;

    logic clk;
    logic rst_n;

    tqlru_req_if #(.PAGE_BITS(PAGE_BITS_DEF)) req ();
    tqlru_rsp_if rsp ();
    tqlru_cfg_if cfg ();

    tenant_quota_lru_replacement_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // buffer model state
    logic [27:0] prio_tbl;
    logic [19:0] minq_tbl;
    logic [19:0] maxq_tbl;
    bit          occ [NSLOT];
    int          owner [NSLOT];
    int          page_of [NSLOT];
    int          age [NSLOT];
    int          held [NTEN];
    int          fill_ptr;

    page_req_t   pending_reqs[$];
    slot_grant_t expected_grants[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          mismatches;
    int          stall_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int quota_field(logic [19:0] tbl, int t);
        return int'((tbl >> (t * QUOTA_W)) & 20'h1F);
    endfunction

    function automatic int prio_field(int t);
        return int'((prio_tbl >> (t * PRIO_W)) & 28'h7F);
    endfunction

    function automatic void touch_slot(int s);
        int r;
        r = age[s];
        for (int j = 0; j < NSLOT; j++)
            if (occ[j] && j != s && age[j] < r) age[j]++;
        age[s] = 0;
    endfunction

    // work out the grant for one request and update the buffer model
    function automatic slot_grant_t serve_page(page_req_t r);
        slot_grant_t g;
        int          u;
        int          best;
        int          best_prio;
        int          cnt;
        int          mn;
        int          pr;
        int          o;
        bit          found;
        u = int'(r.tenant);
        g.slot = '0;
        g.hit = 1'b0;
        g.status = 1'b1;
        // hit lookup
        for (int s = 0; s < NSLOT; s++)
        begin
            if (occ[s] && owner[s] == u && page_of[s] == int'(r.page))
            begin
                touch_slot(s);
                g.slot = s[SLOT_W-1:0];
                g.hit = 1'b1;
                g.status = 1'b0;
                return g;
            end
        end
        // tenant at its maximum reuses its own oldest slot
        if (held[u] == quota_field(maxq_tbl, u))
        begin
            found = 0;
            best = 0;
            for (int s = 0; s < NSLOT; s++)
                if (occ[s] && owner[s] == u && (!found || age[s] > age[best]))
                begin
                    best = s;
                    found = 1;
                end
            if (!found)
                return g;
            page_of[best] = int'(r.page);
            touch_slot(best);
            g.slot = best[SLOT_W-1:0];
            g.status = 1'b0;
            return g;
        end
        // free slot in order
        if (fill_ptr < NSLOT)
        begin
            for (int s = 0; s < NSLOT; s++)
                if (occ[s]) age[s]++;
            occ[fill_ptr] = 1;
            owner[fill_ptr] = u;
            page_of[fill_ptr] = int'(r.page);
            age[fill_ptr] = 0;
            held[u]++;
            g.slot = fill_ptr[SLOT_W-1:0];
            g.status = 1'b0;
            fill_ptr++;
            return g;
        end
        // victim among eligible tenants
        found = 0;
        best = 0;
        best_prio = 0;
        for (int s = 0; s < NSLOT; s++)
        begin
            if (!occ[s])
                continue;
            o = owner[s];
            cnt = held[o];
            mn = quota_field(minq_tbl, o);
            if (!(cnt > mn || (o == u && cnt >= mn)))
                continue;
            pr = prio_field(o);
            if (!found || pr < best_prio || (pr == best_prio && age[s] > age[best]))
            begin
                found = 1;
                best = s;
                best_prio = pr;
            end
        end
        if (!found)
            return g;
        held[owner[best]]--;
        owner[best] = u;
        page_of[best] = int'(r.page);
        held[u]++;
        touch_slot(best);
        g.slot = best[SLOT_W-1:0];
        g.status = 1'b0;
        return g;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.tenant_id <= '0;
            req.page_number <= '0;
        end
        else if (!req.valid || req.ready)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req.valid <= 1'b1;
                req.tenant_id <= pending_reqs[0].tenant;
                req.page_number <= pending_reqs[0].page;
                void'(pending_reqs.pop_front());
            end
            else
                req.valid <= 1'b0;
        end
    end

    // monitor: predict on request accept, check on response accept
    always @(posedge clk or negedge rst_n)
    begin
        page_req_t   r;
        slot_grant_t e;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_cycles <= 0;
        end
        else
        begin
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
                (cfg.valid && cfg.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (req.valid && req.ready)
            begin
                r.tenant = req.tenant_id;
                r.page = req.page_number;
                expected_grants.push_back(serve_page(r));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response word slot %0d hit %0b status %0b",
                                 rsp.slot_index, rsp.was_hit, rsp.status);
                end
                else
                begin
                    e = expected_grants.pop_front();
                    if (rsp.slot_index !== e.slot || rsp.was_hit !== e.hit ||
                        rsp.status !== e.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response mismatch: exp slot %0d hit %0b status %0b, got slot %0d hit %0b status %0b",
                                     e.slot, e.hit, e.status,
                                     rsp.slot_index, rsp.was_hit, rsp.status);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tenant_quota_lru_replacement_unit test failed");
            $finish;
        end
    end

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [27:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            REG_PRIO: prio_tbl = value;
            REG_MINQ: minq_tbl = value[19:0];
            REG_MAXQ: maxq_tbl = value[19:0];
            default: ;
        endcase
    endtask

    task automatic set_quotas(logic [27:0] p, logic [19:0] mn, logic [19:0] mx);
        reg_write(REG_PRIO, p);
        reg_write(REG_MINQ, {8'hAB, mn});
        reg_write(REG_MAXQ, {8'hCD, mx});
    endtask

    task automatic push_page(int t, int pg);
        page_req_t r;
        r.tenant = t[TID_W-1:0];
        r.page = pg[PAGE_BITS_DEF-1:0];
        pending_reqs.push_back(r);
    endtask

    // mostly a small page pool per tenant so hits and reuse happen often
    task automatic push_random_pages(int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                push_page($urandom_range(NTEN - 1), $urandom_range(11));
            else if (pick < 80)
                push_page($urandom_range(NTEN - 1), ($urandom_range(1) != 0) ? 16'hFFFF : 16'h8000);
            else
                push_page($urandom_range(NTEN - 1), $urandom_range(16'hFFFF));
        end
    endtask

    // wait until everything sent has been answered, then let the unit settle
    task automatic drain;
        while (pending_reqs.size() > 0 || req.valid || expected_grants.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [19:0] pack_quota(int a, int b, int c, int d);
        return {a[4:0], b[4:0], c[4:0], d[4:0]};
    endfunction

    // stimulus and phase control
    initial
    begin
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        send_idle_pct = 27;
        recv_idle_pct = 80;
        mismatches = 0;
        prio_tbl = PRIO_RESET;
        minq_tbl = MINQ_RESET;
        maxq_tbl = MAXQ_RESET;
        fill_ptr = 0;
        for (int s = 0; s < NSLOT; s++)
        begin
            occ[s] = 0;
            owner[s] = 0;
            page_of[s] = 0;
            age[s] = 0;
        end
        for (int t = 0; t < NTEN; t++)
            held[t] = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: hit, extremes, fill to full, then victims at reset registers
        push_page(0, 0);
        push_page(0, 0);
        push_page(3, 16'hFFFF);
        push_page(3, 16'hFFFF);
        push_page(1, 16'h5555);
        push_page(2, 16'hAAAA);
        for (int i = 0; i < 12; i++)
            push_page(i % NTEN, 16'h0100 + i);
        push_page(0, 16'h7777);
        push_page(1, 16'h1234);
        push_page(3, 16'hFFFF);
        push_page(2, 16'hAAAA);
        push_page(0, 16'h0000);
        drain();

        // priority order with a value above 100, real minimums
        set_quotas({7'd100, 7'd0, 7'd50, 7'd127}, pack_quota(3, 0, 1, 2),
                   pack_quota(8, 16, 5, 16));
        reg_write(REG_UNUSED, 28'hFFFFFFF);
        push_random_pages(70);
        drain();
        // a second batch at the same settings, after the first has fully drained
        push_random_pages(70);
        drain();

        // maximum quotas lowered below current counts
        send_idle_pct = 80;
        recv_idle_pct = 27;
        set_quotas(28'h0000000, 20'h00000, pack_quota(2, 3, 1, 2));
        push_random_pages(140);
        drain();

        // no victim and zero maximum: minimums at the top
        set_quotas(28'hFFFFFFF, 20'hFFFFF, pack_quota(0, 31, 0, 31));
        push_random_pages(120);
        drain();

        // every maximum at its top value of 31
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_quotas(28'hFFFFFFF, 20'h00000, 20'hFFFFF);
        push_random_pages(140);
        drain();

        // random settings
        for (int k = 0; k < 3; k++)
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            set_quotas(28'($urandom_range(28'hFFFFFFF)),
                       pack_quota($urandom_range(3), $urandom_range(3),
                                  $urandom_range(3), $urandom_range(3)),
                       pack_quota($urandom_range(2, 8), $urandom_range(2, 8),
                                  $urandom_range(2, 8), $urandom_range(2, 8)));
            push_random_pages(100);
            drain();
        end

        if (mismatches == 0)
            $display("tenant_quota_lru_replacement_unit test passed");
        else
            $display("tenant_quota_lru_replacement_unit test failed");
        $finish;
    end

endmodule
